// ----- src/rrs_pkg.sv -----
// Package: shared types and constants for the route reply selector.
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;
  localparam int STORE_DEPTH_DEF = 10;
  localparam int MAX_TOKENS_DEF  = 63;
  localparam logic [9:0] VALUE_MAX = 10'd1023;
  localparam logic [7:0] SEP_CHAR  = 8'h3B;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;
  localparam logic [8:0] RSSI_FLOOR_RST = 9'h188;
  localparam logic [15:0] WINDOW_RST = 16'd5000;

  localparam logic [1:0] REG_GATEWAY = 2'd0;
  localparam logic [1:0] REG_FLOOR   = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;

  typedef struct packed {
    logic signed [8:0] rssi;
    logic [5:0]  gw_hops;
    logic [7:0]  tokens;
    logic [7:0]  second_id;
    logic        second_ok;
    logic [31:0] now_ms;
  } reply_t;
endpackage
`default_nettype wire

// ----- src/rrs_ram.sv -----
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     waddr,
  input  wire [WIDTH-1:0]  wdata,
  input  wire [AW-1:0]     raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/rrs_front.sv -----
// Front: character parser producing one summary per completed reply.
`timescale 1ns / 1ps
`default_nettype none
module rrs_front #(
  parameter int MAX_TOKENS = 63
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire [7:0]    char_code,
  input  wire          last_char,
  input  wire [8:0]    rssi,
  input  wire [31:0]   now_ms,
  input  wire [7:0]    gw_node,
  output logic         q_valid,
  input  wire          q_ready,
  output rrs_pkg::reply_t q_data
);
  import rrs_pkg::*;
  logic [9:0] value;
  logic [7:0] tcount, gcount, sec_id;
  logic nonempty, stopped, digit, gw_found, sec_ok;
  logic [9:0] v_c;
  logic [7:0] tc_c, gc_c, sid_c;
  logic ne_c, st_c, dg_c, gf_c, so_c;
  logic [13:0] mac;
  logic is_digit;

  assign in_ready = !q_valid || q_ready;
  assign is_digit = char_code >= ZERO_CHAR && char_code <= NINE_CHAR;
  assign mac = {4'd0, value} * 14'd10 + {10'd0, char_code[3:0]};

  always_comb begin
    v_c = value; tc_c = tcount; gc_c = gcount; sid_c = sec_id;
    ne_c = nonempty; st_c = stopped; dg_c = digit; gf_c = gw_found; so_c = sec_ok;
    if (char_code != SEP_CHAR) begin
      ne_c = 1'b1;
      if (is_digit && !stopped) begin
        v_c = (mac > {4'd0, VALUE_MAX}) ? VALUE_MAX : mac[9:0];
        dg_c = 1'b1;
      end else begin
        st_c = 1'b1;
      end
    end
    if ((char_code == SEP_CHAR || last_char) && ne_c) begin
      if (tc_c < 8'(MAX_TOKENS)) tc_c = tc_c + 8'd1;
      if (tc_c == 8'd2 && !so_c && sid_c == 8'd0) begin
        sid_c = v_c[7:0];
        so_c = dg_c;
      end
      if (!gf_c) begin
        gc_c = tc_c;
        if (v_c == {2'd0, gw_node}) gf_c = 1'b1;
      end
      v_c = '0; ne_c = 1'b0; st_c = 1'b0; dg_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0; tcount <= '0; gcount <= '0; sec_id <= '0;
      nonempty <= 1'b0; stopped <= 1'b0; digit <= 1'b0;
      gw_found <= 1'b0; sec_ok <= 1'b0; q_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready) q_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (last_char) begin
          value <= '0; tcount <= '0; gcount <= '0; sec_id <= '0;
          nonempty <= 1'b0; stopped <= 1'b0; digit <= 1'b0;
          gw_found <= 1'b0; sec_ok <= 1'b0;
          q_valid <= 1'b1;
          q_data.rssi <= rssi;
          q_data.gw_hops <= gf_c ? gc_c[5:0] : 6'd0;
          q_data.tokens <= tc_c;
          q_data.second_id <= sid_c;
          q_data.second_ok <= so_c;
          q_data.now_ms <= now_ms;
        end else begin
          value <= v_c; tcount <= tc_c; gcount <= gc_c; sec_id <= sid_c;
          nonempty <= ne_c; stopped <= st_c; digit <= dg_c;
          gw_found <= gf_c; sec_ok <= so_c;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/rrs_back.sv -----
// Back: store, route update and windowed best-entry evaluation.
`timescale 1ns / 1ps
`default_nettype none
module rrs_back #(
  parameter int STORE_DEPTH = 10
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          q_valid,
  output logic         q_ready,
  input  rrs_pkg::reply_t q_data,
  input  wire [8:0]    rssi_floor,
  input  wire [15:0]   window_ms,
  output logic         m_valid,
  input  wire          m_ready,
  output logic [31:0]  m_data
);
  import rrs_pkg::*;
  localparam int AW = $clog2(STORE_DEPTH + 1);
  localparam int RAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int EW = 24;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_LAST = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state;

  logic [5:0] cur_gw;
  logic [AW-1:0] count, ridx;
  logic [7:0] next_hop, old_nh;
  logic signed [6:0] hops, old_hops;
  logic [31:0] last_eval;
  logic stored, dropped, do_eval;
  logic [5:0] best_gw;
  logic signed [8:0] best_rssi;
  logic [7:0] best_tok, best_sid;
  logic best_ok, have_best;
  logic [EW-1:0] rdata;
  logic we, qual;
  logic [31:0] elapsed;
  logic [5:0] e_gw;
  logic signed [8:0] e_rssi;
  logic [7:0] e_tok;
  logic e_ok;

  assign {e_rssi, e_gw, e_tok, e_ok} = {rdata[23:1], rdata[0]};
  assign q_ready = state == S_IDLE;
  assign qual = $signed(q_data.rssi) > $signed(rssi_floor);
  assign we = q_valid && q_ready && qual && count < AW'(STORE_DEPTH) &&
              q_data.gw_hops != 6'd0;
  assign elapsed = q_data.now_ms - last_eval;

  logic [7:0] sid_r;

  rrs_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH), .AW(RAW)) u_ram (
    .clk(clk), .we(we), .waddr(count[RAW-1:0]),
    .wdata({q_data.rssi, q_data.gw_hops, q_data.tokens, q_data.second_ok}),
    .raddr(ridx[RAW-1:0]), .rdata(rdata)
  );
  rrs_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH), .AW(RAW)) u_sid (
    .clk(clk), .we(we), .waddr(count[RAW-1:0]), .wdata(q_data.second_id),
    .raddr(ridx[RAW-1:0]), .rdata(sid_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; next_hop <= '0; hops <= '0;
      last_eval <= '0; m_valid <= 1'b0; ridx <= '0;
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          cur_gw <= q_data.gw_hops;
          old_nh <= next_hop; old_hops <= hops;
          stored <= we; dropped <= qual && count >= AW'(STORE_DEPTH);
          if (we) count <= count + AW'(1);
          if (qual && $signed({1'b0, q_data.gw_hops}) < hops) begin
            hops <= 7'(q_data.tokens) - 7'sd1;
            if (q_data.second_ok) next_hop <= q_data.second_id;
          end
          do_eval <= 1'b0; have_best <= 1'b0; ridx <= '0;
          if (elapsed > {16'd0, window_ms}) begin
            last_eval <= q_data.now_ms;
            if (count != '0 || we) begin
              do_eval <= 1'b1;
              state <= S_SCAN;
            end else state <= S_OUT;
            if (!(count != '0 || we)) count <= '0;
          end else state <= S_OUT;
        end
        S_SCAN: begin
          state <= (ridx + AW'(1) >= count) ? S_LAST : S_SCAN;
          ridx <= ridx + AW'(1);
          if (have_best && ridx != '0) begin
            if (e_gw < best_gw || (e_gw == best_gw && e_rssi > best_rssi)) begin
              best_gw <= e_gw; best_rssi <= e_rssi; best_tok <= e_tok;
              best_sid <= sid_r; best_ok <= e_ok;
            end
          end else if (ridx != '0) begin
            have_best <= 1'b1;
            best_gw <= e_gw; best_rssi <= e_rssi; best_tok <= e_tok;
            best_sid <= sid_r; best_ok <= e_ok;
          end
        end
        S_LAST: begin
          logic [7:0] t, s; logic o;
          t = best_tok; s = best_sid; o = best_ok;
          if (!have_best || e_gw < best_gw || (e_gw == best_gw && e_rssi > best_rssi))
          begin
            t = e_tok; s = sid_r; o = e_ok;
          end
          hops <= 7'(t) - 7'sd1;
          if (o) next_hop <= s;
          count <= '0;
          state <= S_OUT;
        end
        S_OUT: if (!m_valid || m_ready) begin
          m_valid <= 1'b1;
          m_data <= {7'd0, do_eval,
                     (next_hop != old_nh || hops != old_hops),
                     dropped, stored, cur_gw, hops, next_hop};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/route_reply_selector.sv -----
// Top level: route reply selector with stream ports and register channel.
`timescale 1ns / 1ps
`default_nettype none
// A reply enters one character per item; the parser takes one item a cycle
// unless its queued summary is still waiting to be taken, and it queues a
// summary on the last character. The back end takes a summary in its idle
// state and goes to its output state; when the window expires and the store
// holds entries, it first walks them through the store RAM read port.
// A waiting result holds the back end in its output state while the parser
// keeps taking characters until the queue is full. One result item per reply.
// Registers are written through the cfg channel, always ready.
module route_reply_selector #(
  parameter int STORE_DEPTH = rrs_pkg::STORE_DEPTH_DEF,
  parameter int MAX_TOKENS  = rrs_pkg::MAX_TOKENS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [55:0]  s_tdata,   // char_code, rssi, now_ms, zero pad
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // next_hop, hops, gw_hops, stored, dropped, updated,
                                 // evaluated, zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [15:0]  cfg_data
);
  import rrs_pkg::*;
  logic [7:0] gw_node;
  logic [8:0] rssi_floor;
  logic [15:0] window_ms;
  logic qv, qr;
  reply_t qd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gw_node <= '0; rssi_floor <= RSSI_FLOOR_RST; window_ms <= WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GATEWAY: gw_node    <= cfg_data[7:0];
        REG_FLOOR:   rssi_floor <= cfg_data[8:0];
        REG_WINDOW:  window_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  rrs_front #(.MAX_TOKENS(MAX_TOKENS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .char_code(s_tdata[7:0]), .last_char(s_tlast), .rssi(s_tdata[16:8]),
    .now_ms(s_tdata[48:17]), .gw_node(gw_node),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );
  rrs_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(qv), .q_ready(qr), .q_data(qd),
    .rssi_floor(rssi_floor), .window_ms(window_ms),
    .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
  );
endmodule
`default_nettype wire
